// ===== rtl/bsif_pkg.sv =====
// ----------------------------------------------------------------------------
// bsif_pkg
// Shared types and constants of the image feature code histogram unit.
// ----------------------------------------------------------------------------
package bsif_pkg;

    localparam int MAX_ROWS_DEF   = 128;
    localparam int MAX_COLS_DEF   = 512;
    localparam int MAX_KERNEL_DEF = 17;
    localparam int MAX_BITS_DEF   = 12;

    localparam logic [1:0] CMD_LOAD_COEF  = 2'd0;
    localparam logic [1:0] CMD_LOAD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_RUN        = 2'd2;
    localparam logic [1:0] CMD_READ_BIN   = 2'd3;

    localparam logic [2:0] REG_KERNEL_SIZE = 3'd0;
    localparam logic [2:0] REG_CODE_BITS   = 3'd1;
    localparam logic [2:0] REG_IMAGE_ROWS  = 3'd2;
    localparam logic [2:0] REG_IMAGE_COLS  = 3'd3;
    localparam logic [2:0] REG_THRESHOLD   = 3'd4;

    localparam logic RESULT_RUN_DONE = 1'b0;
    localparam logic RESULT_BIN_DATA = 1'b1;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         filter_index;
        logic [4:0]         coef_row;
        logic [4:0]         coef_col;
        logic signed [15:0] coef_value;
        logic [6:0]         pixel_row;
        logic [8:0]         pixel_col;
        logic [7:0]         pixel_value;
        logic [12:0]        bin_index;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [12:0] bin_number;
        logic [16:0] bin_count;
    } out_t;

endpackage

// ===== rtl/bsif_code_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// bsif_code_histogram_unit
// Binarized filter response codes of a stored image, counted into a histogram.
// ----------------------------------------------------------------------------
// Coefficient and pixel loads give no result. A run first clears the
// 2^MAX_BITS+1 histogram bins, one bin per cycle, then visits every pixel:
// for each filter it streams the kernel taps through one multiplier, one tap
// per cycle from the pixel and coefficient memories. A bin read passes
// through the registered histogram memory read and the RDWAIT and OUT states.
// After reset the same clearing pass runs and s_ready stays low until it ends.
module bsif_code_histogram_unit #(
    parameter int MAX_ROWS   = bsif_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = bsif_pkg::MAX_COLS_DEF,
    parameter int MAX_KERNEL = bsif_pkg::MAX_KERNEL_DEF,
    parameter int MAX_BITS   = bsif_pkg::MAX_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bsif_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bsif_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [9:0]     cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int PAW   = RW + CW;
    localparam int PDEPTH = 1 << PAW;
    localparam int KK    = MAX_KERNEL * MAX_KERNEL;
    localparam int CDEPTH = MAX_BITS * KK;
    localparam int CAW   = $clog2(CDEPTH);
    localparam int BDEPTH = (1 << MAX_BITS) + 1;
    localparam int BAW   = MAX_BITS + 1;
    localparam int FW    = $clog2(MAX_BITS);
    localparam int KW    = $clog2(MAX_KERNEL);
    localparam int AW    = 25 + $clog2(KK);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SETUP  = 4'd2;
    localparam logic [3:0] S_ISSUE  = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_BINRD  = 4'd5;
    localparam logic [3:0] S_BINWR  = 4'd6;
    localparam logic [3:0] S_RDWAIT = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [7:0]  pix_mem  [PDEPTH];
    logic [15:0] coef_mem [CDEPTH];
    logic [16:0] bin_mem  [BDEPTH];

    logic [3:0]    state_reg;
    logic          run_pend_reg;
    logic [BAW-1:0] clr_cnt_reg;
    logic [4:0]    ks_reg;
    logic [3:0]    nb_reg;
    logic [RW:0]   rows_reg;
    logic [CW:0]   cols_reg;
    logic [9:0]    thr_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [FW-1:0] f_reg;
    logic [KW-1:0] u_reg;
    logic [KW-1:0] v_reg;
    logic [RW-1:0] pr_reg;
    logic [CW-1:0] pc_reg;
    logic [CAW-1:0] fbase_reg;
    logic [CAW-1:0] rbase_reg;
    logic [MAX_BITS-1:0] code_reg;
    logic [BAW-1:0] bin_addr_reg;
    logic          bin_ok_reg;
    logic [12:0]   bin_num_reg;
    logic          kind_reg;
    logic [16:0]   bin_rdata_reg;
    logic [7:0]    pix_q_reg;
    logic signed [15:0] coef_q_reg;
    logic          v1_reg;
    logic          last1_reg;
    logic          v2_reg;
    logic          last2_reg;
    logic signed [24:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic          m_valid_reg;
    bsif_pkg::out_t m_data_reg;

    logic [3:0]    h;
    logic [RW-1:0] row_start;
    logic [CW-1:0] col_start;
    logic [PAW-1:0] pix_rd_addr;
    logic [CAW-1:0] coef_rd_addr;
    logic          issue_last;
    logic signed [AW-1:0] resp;
    logic          hit;
    logic [MAX_BITS-1:0] code_next;
    logic          s_acc;
    logic [4:0]    ks_in;
    logic [3:0]    nb_in;
    logic [RW:0]   rows_in;
    logic [CW:0]   cols_in;
    logic          bin_we;
    logic [BAW-1:0] bin_waddr;
    logic [16:0]   bin_wdata;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign h = 4'(ks_reg >> 1);
    assign row_start = (r_reg >= RW'(h)) ? RW'(r_reg - RW'(h))
                                         : RW'({1'b0, r_reg} + rows_reg - (RW + 1)'(h));
    assign col_start = (c_reg >= CW'(h)) ? CW'(c_reg - CW'(h))
                                         : CW'({1'b0, c_reg} + cols_reg - (CW + 1)'(h));
    assign pix_rd_addr  = {pr_reg, pc_reg};
    assign coef_rd_addr = CAW'(rbase_reg + CAW'(v_reg));
    assign issue_last   = (u_reg == KW'(ks_reg - 5'd1)) && (v_reg == KW'(ks_reg - 5'd1));
    assign resp = acc_reg + AW'(prod_reg);
    assign hit  = resp > $signed({{(AW - 10){1'b0}}, thr_reg});
    assign code_next = {code_reg[MAX_BITS-2:0], hit};

    always_comb begin
        ks_in = cfg_data[4:0] | 5'd1;
        if (ks_in < 5'd3) begin
            ks_in = 5'd3;
        end else if (32'(ks_in) > MAX_KERNEL) begin
            ks_in = 5'(MAX_KERNEL);
        end
        nb_in = cfg_data[3:0];
        if (nb_in < 4'd5) begin
            nb_in = 4'd5;
        end else if (32'(nb_in) > MAX_BITS) begin
            nb_in = 4'(MAX_BITS);
        end
        rows_in = (RW + 1)'(cfg_data[7:0]);
        if (cfg_data[7:0] < 8'd8) begin
            rows_in = (RW + 1)'(8);
        end else if (32'(cfg_data[7:0]) > MAX_ROWS) begin
            rows_in = (RW + 1)'(MAX_ROWS);
        end
        cols_in = (CW + 1)'(cfg_data);
        if (cfg_data < 10'd8) begin
            cols_in = (CW + 1)'(8);
        end else if (32'(cfg_data) > MAX_COLS) begin
            cols_in = (CW + 1)'(MAX_COLS);
        end
    end

    always_comb begin
        bin_we    = 1'b0;
        bin_waddr = bin_addr_reg;
        bin_wdata = (bin_rdata_reg == bsif_pkg::COUNT_MAX) ? bin_rdata_reg
                                                           : bin_rdata_reg + 17'd1;
        case (state_reg)
            S_CLEAR: begin
                bin_we    = 1'b1;
                bin_waddr = clr_cnt_reg;
                bin_wdata = '0;
            end
            S_BINWR: begin
                bin_we = 1'b1;
            end
            default: begin
                bin_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.cmd == bsif_pkg::CMD_LOAD_PIXEL &&
            32'(s_data.pixel_row) < MAX_ROWS && 32'(s_data.pixel_col) < MAX_COLS) begin
            pix_mem[{RW'(s_data.pixel_row), CW'(s_data.pixel_col)}] <= s_data.pixel_value;
        end
        pix_q_reg <= pix_mem[pix_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.cmd == bsif_pkg::CMD_LOAD_COEF &&
            32'(s_data.filter_index) < MAX_BITS && 32'(s_data.coef_row) < MAX_KERNEL &&
            32'(s_data.coef_col) < MAX_KERNEL) begin
            coef_mem[CAW'(CAW'(s_data.filter_index) * CAW'(KK)
                     + CAW'(s_data.coef_row) * CAW'(MAX_KERNEL)
                     + CAW'(s_data.coef_col))] <= s_data.coef_value;
        end
        coef_q_reg <= coef_mem[coef_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (bin_we) begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        bin_rdata_reg <= bin_mem[bin_addr_reg];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= coef_q_reg * $signed({1'b0, pix_q_reg});
        if (v2_reg) begin
            acc_reg <= last2_reg ? '0 : resp;
        end
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg <= (state_reg == S_ISSUE);
            v2_reg <= v1_reg;
        end
        last1_reg <= issue_last;
        last2_reg <= last1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            run_pend_reg <= 1'b0;
            clr_cnt_reg  <= '0;
            ks_reg       <= 5'd3;
            nb_reg       <= 4'd8;
            rows_reg     <= (RW + 1)'(64 > MAX_ROWS ? MAX_ROWS : 64);
            cols_reg     <= (CW + 1)'(512 > MAX_COLS ? MAX_COLS : 512);
            thr_reg      <= 10'd4;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bsif_pkg::REG_KERNEL_SIZE: ks_reg   <= ks_in;
                    bsif_pkg::REG_CODE_BITS:   nb_reg   <= nb_in;
                    bsif_pkg::REG_IMAGE_ROWS:  rows_reg <= rows_in;
                    bsif_pkg::REG_IMAGE_COLS:  cols_reg <= cols_in;
                    bsif_pkg::REG_THRESHOLD:   thr_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == BAW'(BDEPTH - 1)) begin
                        r_reg     <= '0;
                        c_reg     <= '0;
                        f_reg     <= '0;
                        fbase_reg <= '0;
                        code_reg  <= '0;
                        state_reg <= run_pend_reg ? S_SETUP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        case (s_data.cmd)
                            bsif_pkg::CMD_RUN: begin
                                run_pend_reg <= 1'b1;
                                clr_cnt_reg  <= '0;
                                state_reg    <= S_CLEAR;
                            end
                            bsif_pkg::CMD_READ_BIN: begin
                                bin_addr_reg <= BAW'(s_data.bin_index);
                                bin_ok_reg   <= 32'(s_data.bin_index) < BDEPTH;
                                bin_num_reg  <= s_data.bin_index;
                                kind_reg     <= bsif_pkg::RESULT_BIN_DATA;
                                state_reg    <= S_RDWAIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SETUP: begin
                    u_reg     <= '0;
                    v_reg     <= '0;
                    pr_reg    <= row_start;
                    pc_reg    <= col_start;
                    rbase_reg <= fbase_reg;
                    state_reg <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (v_reg == KW'(ks_reg - 5'd1)) begin
                        v_reg  <= '0;
                        pc_reg <= col_start;
                        if (u_reg == KW'(ks_reg - 5'd1)) begin
                            state_reg <= S_DRAIN;
                        end else begin
                            u_reg     <= u_reg + 1'b1;
                            pr_reg    <= ((RW + 1)'(pr_reg) == rows_reg - 1'b1) ? '0
                                                                             : pr_reg + 1'b1;
                            rbase_reg <= CAW'(rbase_reg + CAW'(MAX_KERNEL));
                        end
                    end else begin
                        v_reg  <= v_reg + 1'b1;
                        pc_reg <= ((CW + 1)'(pc_reg) == cols_reg - 1'b1) ? '0
                                                                         : pc_reg + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (v2_reg && last2_reg) begin
                        code_reg <= code_next;
                        if (f_reg == FW'(nb_reg - 4'd1)) begin
                            bin_addr_reg <= BAW'(code_next) + 1'b1;
                            state_reg    <= S_BINRD;
                        end else begin
                            f_reg     <= f_reg + 1'b1;
                            fbase_reg <= CAW'(fbase_reg + CAW'(KK));
                            state_reg <= S_SETUP;
                        end
                    end
                end
                S_BINRD: begin
                    state_reg <= S_BINWR;
                end
                S_BINWR: begin
                    f_reg     <= '0;
                    fbase_reg <= '0;
                    code_reg  <= '0;
                    state_reg <= S_SETUP;
                    if ((CW + 1)'(c_reg) == cols_reg - 1'b1) begin
                        c_reg <= '0;
                        r_reg <= r_reg + 1'b1;
                        if ((RW + 1)'(r_reg) == rows_reg - 1'b1) begin
                            run_pend_reg <= 1'b0;
                            bin_ok_reg   <= 1'b0;
                            bin_num_reg  <= '0;
                            kind_reg     <= bsif_pkg::RESULT_RUN_DONE;
                            state_reg    <= S_OUT;
                        end
                    end else begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                S_RDWAIT: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.result_kind <= kind_reg;
                        m_data_reg.bin_number  <= bin_num_reg;
                        m_data_reg.bin_count   <= bin_ok_reg ? bin_rdata_reg : '0;
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
